[rtl/lpe_pkg.sv]
// shared types, constants and fixed point helpers for the linear polynomial eos unit
package lpe_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  localparam int DIV_LAT = DW + 3;
  localparam int SQ_W = (DW + FB) / 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DW-1:0] fx_t;
  typedef logic [DW-2:0] fxu_t;
  typedef logic signed [2*DW-1:0] wide_t;

  typedef struct packed {
    logic sat;
    fx_t  val;
  } fx_res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ZERO,
    CFG_COEF_ONE,
    CFG_COEF_TWO,
    CFG_COEF_THREE,
    CFG_COEF_FOUR,
    CFG_COEF_FIVE,
    CFG_COEF_SIX,
    CFG_REF_DENSITY
  } cfg_idx_t;

  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam fx_t FX_ONE = fx_t'(64'd1 << FB);
  localparam fx_t FX_LSB = fx_t'(1);
  localparam fxu_t REF_RESET = fxu_t'(64'd1 << FB);
  localparam wide_t TRUNC_BIAS = (wide_t'(1) <<< FB) - wide_t'(1);

  function automatic fx_res_t fx_clamp(wide_t x);
    fx_res_t r;
    if (x > wide_t'(FX_MAX)) begin
      r.sat = 1'b1;
      r.val = FX_MAX;
    end else if (x < wide_t'(FX_MIN)) begin
      r.sat = 1'b1;
      r.val = FX_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = fx_t'(x);
    end
    return r;
  endfunction

  function automatic fx_res_t fx_add(fx_t a, fx_t b);
    return fx_clamp(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic fx_res_t fx_sub(fx_t a, fx_t b);
    return fx_clamp(wide_t'(a) - wide_t'(b));
  endfunction

  // product truncated toward zero
  function automatic fx_res_t fx_mul(fx_t a, fx_t b);
    wide_t prod;
    wide_t adj;
    prod = a * b;
    adj = prod[2*DW-1] ? prod + TRUNC_BIAS : prod;
    return fx_clamp(adj >>> FB);
  endfunction

endpackage

[rtl/lpe_div.sv]
// pipelined fixed point divider, one quotient bit per stage, saturating
module lpe_div (
  input  logic         clk,
  input  lpe_pkg::fx_t  num,
  input  lpe_pkg::fxu_t den,
  output lpe_pkg::fx_t  quo,
  output logic         sat
);
  import lpe_pkg::*;

  typedef struct packed {
    fxu_t          rem;
    logic [DW-1:0] low;
    fxu_t          den;
    logic          neg;
    logic          zero;
    logic          big;
  } div_stage_t;

  localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0] mag_r;
  logic          neg_r;
  fxu_t          den_r;
  div_stage_t    stg_r [DW+1];
  div_stage_t    init_nxt;
  fx_t           quo_r;
  logic          sat_r;
  fx_t           quo_nxt;
  logic          sat_nxt;
  logic [DW-1:0] q_fin;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t    r;
    logic [DW-1:0] t;
    logic          ge;
    t = {s.rem, s.low[DW-1]};
    ge = t >= DW'(s.den);
    r = s;
    r.rem = ge ? fxu_t'(t - DW'(s.den)) : fxu_t'(t);
    r.low = {s.low[DW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    init_nxt.rem = fxu_t'(mag_r >> FB);
    init_nxt.low = mag_r << FB;
    init_nxt.den = den_r;
    init_nxt.neg = neg_r;
    init_nxt.zero = den_r == '0;
    init_nxt.big = (DW+FB)'(mag_r) >= ((DW+FB)'(den_r) << FB);
  end

  assign q_fin = stg_r[DW].low;

  always_comb begin
    if (stg_r[DW].zero || stg_r[DW].big) begin
      sat_nxt = 1'b1;
      quo_nxt = stg_r[DW].neg ? FX_MIN : FX_MAX;
    end else if (stg_r[DW].neg) begin
      sat_nxt = q_fin > NEG_LIM;
      quo_nxt = sat_nxt ? FX_MIN : -fx_t'(q_fin);
    end else begin
      sat_nxt = q_fin[DW-1];
      quo_nxt = sat_nxt ? FX_MAX : fx_t'(q_fin);
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= num[DW-1] ? -num : num;
    neg_r <= num[DW-1];
    den_r <= den;
    stg_r[0] <= init_nxt;
    for (int i = 1; i <= DW; i++) begin
      stg_r[i] <= div_step(stg_r[i-1]);
    end
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

[rtl/linear_polynomial_eos_unit.sv]
// linear polynomial equation of state evaluator, fully pipelined
// Takes one cell word every clock cycle and never raises busy. Each result word
// appears on the out_ ports with out_strobe high, in the order of acceptance;
// the receiver cannot stall it. Each word passes through the input register, two
// 35-stage bit-per-stage dividers in series (the compression and the sound speed
// quotients), ten multiply and add stages between them, one stage that sums and
// floors the squared speed, and a 24-stage square root. Coefficients are read
// live, so write them only while no word is in flight.
module linear_polynomial_eos_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lpe_pkg::fxu_t                 in_density,
  input  lpe_pkg::fx_t                  in_energy,
  input  lpe_pkg::fxu_t                 in_new_volume,
  input  lpe_pkg::fxu_t                 in_old_volume,
  output logic                          out_strobe,
  output lpe_pkg::fx_t                  out_pressure,
  output lpe_pkg::fxu_t                 out_sound_speed,
  output lpe_pkg::fx_t                  out_predicted_pressure,
  output logic                          out_speed_floored,
  output logic                          out_overflow,
  input  logic                          cfg_we,
  input  logic [lpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpe_pkg::DW-1:0]        cfg_data
);
  import lpe_pkg::*;

  localparam int SQ_REM_W = SQ_W + 3;
  localparam int TAIL_LEN = SQ_W - 2;
  localparam int OUT_STAGE = 2 * DIV_LAT + 11 + SQ_W;

  typedef struct packed {
    fxu_t d;
    fx_t  e;
  } pre_t;

  typedef struct packed {
    fx_t  p;
    fx_t  rel;
    fxu_t d;
    logic ovf;
  } mid_t;

  typedef struct packed {
    fx_t  p;
    fx_t  pr;
    logic floored;
    logic ovf;
  } tail_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_W-1:0]     root;
    logic [2*SQ_W-1:0]   x;
  } sq_stage_t;

  fx_t  c0_r, c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  fxu_t ref_r;
  fx_t  ref_s;

  logic vld_r [OUT_STAGE+1];
  pre_t pre_r [DIV_LAT+1];
  fx_t  dv0_r;
  fxu_t ov0_r;

  fx_t  qu, qv, qr, qa, qb;
  logic su, sv, sr, sa, sb;

  fx_t  u_b_r, v_b_r, rel_b_r, e_b_r;
  fxu_t d_b_r;
  logic ovf_b_r;

  logic comp_c_r, ovf_c_r;
  fx_t  u_c_r, u2_c_r, t5_c_r, t1_c_r, t6_c_r, t2_c_r, v_c_r, rel_c_r, e_c_r;
  fxu_t d_c_r;

  logic comp_d_r, ovf_d_r;
  fx_t  u3_d_r, t6u2_d_r, t2u2_d_r, k0_d_r, g0_d_r, p0_d_r, lin_d_r, a1_d_r;
  fx_t  v_d_r, rel_d_r, e_d_r;
  fxu_t d_d_r;

  logic ovf_e_r;
  fx_t  g_e_r, p1_e_r, k_e_r, m3_e_r, lm_e_r, a1_e_r, v_e_r, rel_e_r, e_e_r;
  fxu_t d_e_r;

  logic ovf_f_r;
  fx_t  gr_f_r, p2_f_r, a2_f_r, le_f_r, g_f_r, e_f_r, v_f_r, rel_f_r;
  fxu_t d_f_r;

  logic ovf_g_r;
  fx_t  ge_g_r, a3_g_r, p2_g_r, g_g_r, v_g_r, rel_g_r;
  fxu_t d_g_r;

  logic ovf_h_r;
  fx_t  p_h_r, a3_h_r, g_h_r, v_h_r, rel_h_r;
  fxu_t d_h_r;

  logic ovf_i_r;
  fx_t  pv_i_r, p_i_r, a3_i_r, g_i_r, v_i_r, rel_i_r;
  fxu_t d_i_r;

  logic ovf_j_r;
  fx_t  pvv_j_r, p_j_r, a3_j_r, g_j_r, rel_j_r;
  fxu_t d_j_r;

  logic ovf_k_r;
  fx_t  b_k_r, a3_k_r, p_k_r, rel_k_r;
  fxu_t d_k_r;

  mid_t mid_r [DIV_LAT];

  logic floored_m_r, ovf_m_r;
  fx_t  s_m_r, p_m_r, rel_m_r;
  fxu_t d_m_r;

  logic floored_n_r, ovf_n_r;
  fx_t  ds_n_r, p_n_r, rel_n_r;

  logic floored_o_r, ovf_o_r;
  fx_t  dsr_o_r, p_o_r;

  tail_t     tail_r [TAIL_LEN];
  sq_stage_t sq_r [SQ_W];
  sq_stage_t sq_init;

  fx_res_t u_nxt;
  logic    comp_nxt;
  fx_res_t u2_nxt, t5_nxt, t1_nxt, t6_nxt, t2_nxt;
  fx_res_t u3_nxt, t6u2_nxt, t2u2_nxt, k0_nxt, g0_nxt, p0_nxt;
  fx_res_t t6x2_nxt, lin_nxt, t2x2_nxt, a1_nxt;
  fx_res_t g_nxt, p1_nxt, kx2_nxt, k_nxt, m3_nxt, lm_nxt;
  fx_res_t gr_nxt, p2_nxt, a2_nxt, le_nxt;
  fx_res_t ge_nxt, a3_nxt, p_nxt, pv_nxt, pvv_nxt, b_nxt;
  fx_res_t s_nxt, ds_nxt, dsr_nxt, pr_nxt;
  logic    floored_nxt;

  function automatic sq_stage_t sq_step(sq_stage_t s);
    sq_stage_t           r;
    logic [SQ_REM_W-1:0] t;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;
    t = {s.rem[SQ_REM_W-3:0], s.x[2*SQ_W-1 -: 2]};
    trial = SQ_REM_W'({s.root, 2'b01});
    ge = t >= trial;
    r.rem = ge ? t - trial : t;
    r.root = {s.root[SQ_W-2:0], ge};
    r.x = s.x << 2;
    return r;
  endfunction

  assign ref_s = fx_t'({1'b0, ref_r});
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      ref_r <= REF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_ZERO:   c0_r <= cfg_data;
        CFG_COEF_ONE:    c1_r <= cfg_data;
        CFG_COEF_TWO:    c2_r <= cfg_data;
        CFG_COEF_THREE:  c3_r <= cfg_data;
        CFG_COEF_FOUR:   c4_r <= cfg_data;
        CFG_COEF_FIVE:   c5_r <= cfg_data;
        CFG_COEF_SIX:    c6_r <= cfg_data;
        CFG_REF_DENSITY: ref_r <= cfg_data[DW-2:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= OUT_STAGE; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i <= OUT_STAGE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  lpe_div u_div_u (
    .clk (clk),
    .num (fx_t'({1'b0, pre_r[0].d})),
    .den (ref_r),
    .quo (qu),
    .sat (su)
  );

  lpe_div u_div_v (
    .clk (clk),
    .num (ref_s),
    .den (pre_r[0].d),
    .quo (qv),
    .sat (sv)
  );

  lpe_div u_div_rel (
    .clk (clk),
    .num (dv0_r),
    .den (ov0_r),
    .quo (qr),
    .sat (sr)
  );

  lpe_div u_div_a (
    .clk (clk),
    .num (a3_k_r),
    .den (ref_r),
    .quo (qa),
    .sat (sa)
  );

  lpe_div u_div_b (
    .clk (clk),
    .num (b_k_r),
    .den (ref_r),
    .quo (qb),
    .sat (sb)
  );

  always_comb begin
    u_nxt = fx_sub(qu, FX_ONE);

    comp_nxt = u_b_r > fx_t'(0);
    u2_nxt = fx_mul(u_b_r, u_b_r);
    t5_nxt = fx_mul(c5_r, u_b_r);
    t1_nxt = fx_mul(c1_r, u_b_r);
    t6_nxt = fx_mul(c6_r, u_b_r);
    t2_nxt = fx_mul(c2_r, u_b_r);

    u3_nxt = fx_mul(u2_c_r, u_c_r);
    t6u2_nxt = fx_mul(c6_r, u2_c_r);
    t2u2_nxt = fx_mul(c2_r, u2_c_r);
    k0_nxt = fx_mul(c3_r, u2_c_r);
    g0_nxt = fx_add(c4_r, t5_c_r);
    p0_nxt = fx_add(c0_r, t1_c_r);
    t6x2_nxt = fx_add(t6_c_r, t6_c_r);
    lin_nxt = fx_add(c5_r, t6x2_nxt.val);
    t2x2_nxt = fx_add(t2_c_r, t2_c_r);
    a1_nxt = fx_add(c1_r, t2x2_nxt.val);

    g_nxt = fx_add(g0_d_r, t6u2_d_r);
    p1_nxt = fx_add(p0_d_r, t2u2_d_r);
    kx2_nxt = fx_add(k0_d_r, k0_d_r);
    k_nxt = fx_add(kx2_nxt.val, k0_d_r);
    m3_nxt = fx_mul(c3_r, u3_d_r);
    lm_nxt = fx_mul(lin_d_r, ref_s);

    gr_nxt = fx_mul(g_e_r, ref_s);
    p2_nxt = fx_add(p1_e_r, m3_e_r);
    a2_nxt = fx_add(a1_e_r, k_e_r);
    le_nxt = fx_mul(lm_e_r, e_e_r);

    ge_nxt = fx_mul(gr_f_r, e_f_r);
    a3_nxt = fx_add(a2_f_r, le_f_r);

    p_nxt = fx_add(p2_g_r, ge_g_r);
    pv_nxt = fx_mul(p_h_r, v_h_r);
    pvv_nxt = fx_mul(pv_i_r, v_i_r);
    b_nxt = fx_mul(pvv_j_r, g_j_r);

    s_nxt = fx_add(qa, qb);
    floored_nxt = s_nxt.val < fx_t'(0);

    ds_nxt = fx_mul(fx_t'({1'b0, d_m_r}), s_m_r);
    dsr_nxt = fx_mul(ds_n_r, rel_n_r);
    pr_nxt = fx_sub(p_o_r, dsr_o_r);

    sq_init.rem = '0;
    sq_init.root = '0;
    sq_init.x = (2*SQ_W)'(s_m_r) << FB;
  end

  always_ff @(posedge clk) begin
    pre_r[0] <= '{d: in_density, e: in_energy};
    dv0_r <= fx_t'({1'b0, in_new_volume}) - fx_t'({1'b0, in_old_volume});
    ov0_r <= in_old_volume;
    for (int i = 1; i <= DIV_LAT; i++) begin
      pre_r[i] <= pre_r[i-1];
    end

    u_b_r <= u_nxt.val;
    v_b_r <= qv;
    rel_b_r <= qr;
    d_b_r <= pre_r[DIV_LAT].d;
    e_b_r <= pre_r[DIV_LAT].e;
    ovf_b_r <= su | sv | sr | u_nxt.sat;

    comp_c_r <= comp_nxt;
    u_c_r <= u_b_r;
    u2_c_r <= u2_nxt.val;
    t5_c_r <= t5_nxt.val;
    t1_c_r <= t1_nxt.val;
    t6_c_r <= t6_nxt.val;
    t2_c_r <= t2_nxt.val;
    v_c_r <= v_b_r;
    rel_c_r <= rel_b_r;
    d_c_r <= d_b_r;
    e_c_r <= e_b_r;
    ovf_c_r <= ovf_b_r | u2_nxt.sat | t5_nxt.sat | t1_nxt.sat
               | (comp_nxt & (t6_nxt.sat | t2_nxt.sat));

    comp_d_r <= comp_c_r;
    u3_d_r <= u3_nxt.val;
    t6u2_d_r <= t6u2_nxt.val;
    t2u2_d_r <= t2u2_nxt.val;
    k0_d_r <= k0_nxt.val;
    g0_d_r <= g0_nxt.val;
    p0_d_r <= p0_nxt.val;
    lin_d_r <= comp_c_r ? lin_nxt.val : c5_r;
    a1_d_r <= comp_c_r ? a1_nxt.val : c1_r;
    v_d_r <= v_c_r;
    rel_d_r <= rel_c_r;
    d_d_r <= d_c_r;
    e_d_r <= e_c_r;
    ovf_d_r <= ovf_c_r | u3_nxt.sat | k0_nxt.sat | g0_nxt.sat | p0_nxt.sat
               | (comp_c_r & (t6u2_nxt.sat | t2u2_nxt.sat | t6x2_nxt.sat
                              | lin_nxt.sat | t2x2_nxt.sat | a1_nxt.sat));

    g_e_r <= comp_d_r ? g_nxt.val : g0_d_r;
    p1_e_r <= comp_d_r ? p1_nxt.val : p0_d_r;
    k_e_r <= k_nxt.val;
    m3_e_r <= m3_nxt.val;
    lm_e_r <= lm_nxt.val;
    a1_e_r <= a1_d_r;
    v_e_r <= v_d_r;
    rel_e_r <= rel_d_r;
    d_e_r <= d_d_r;
    e_e_r <= e_d_r;
    ovf_e_r <= ovf_d_r | kx2_nxt.sat | k_nxt.sat | m3_nxt.sat | lm_nxt.sat
               | (comp_d_r & (g_nxt.sat | p1_nxt.sat));

    gr_f_r <= gr_nxt.val;
    p2_f_r <= p2_nxt.val;
    a2_f_r <= a2_nxt.val;
    le_f_r <= le_nxt.val;
    g_f_r <= g_e_r;
    e_f_r <= e_e_r;
    v_f_r <= v_e_r;
    rel_f_r <= rel_e_r;
    d_f_r <= d_e_r;
    ovf_f_r <= ovf_e_r | gr_nxt.sat | p2_nxt.sat | a2_nxt.sat | le_nxt.sat;

    ge_g_r <= ge_nxt.val;
    a3_g_r <= a3_nxt.val;
    p2_g_r <= p2_f_r;
    g_g_r <= g_f_r;
    v_g_r <= v_f_r;
    rel_g_r <= rel_f_r;
    d_g_r <= d_f_r;
    ovf_g_r <= ovf_f_r | ge_nxt.sat | a3_nxt.sat;

    p_h_r <= p_nxt.val;
    a3_h_r <= a3_g_r;
    g_h_r <= g_g_r;
    v_h_r <= v_g_r;
    rel_h_r <= rel_g_r;
    d_h_r <= d_g_r;
    ovf_h_r <= ovf_g_r | p_nxt.sat;

    pv_i_r <= pv_nxt.val;
    p_i_r <= p_h_r;
    a3_i_r <= a3_h_r;
    g_i_r <= g_h_r;
    v_i_r <= v_h_r;
    rel_i_r <= rel_h_r;
    d_i_r <= d_h_r;
    ovf_i_r <= ovf_h_r | pv_nxt.sat;

    pvv_j_r <= pvv_nxt.val;
    p_j_r <= p_i_r;
    a3_j_r <= a3_i_r;
    g_j_r <= g_i_r;
    rel_j_r <= rel_i_r;
    d_j_r <= d_i_r;
    ovf_j_r <= ovf_i_r | pvv_nxt.sat;

    b_k_r <= b_nxt.val;
    a3_k_r <= a3_j_r;
    p_k_r <= p_j_r;
    rel_k_r <= rel_j_r;
    d_k_r <= d_j_r;
    ovf_k_r <= ovf_j_r | b_nxt.sat;

    mid_r[0] <= '{p: p_k_r, rel: rel_k_r, d: d_k_r, ovf: ovf_k_r};
    for (int i = 1; i < DIV_LAT; i++) begin
      mid_r[i] <= mid_r[i-1];
    end

    s_m_r <= floored_nxt ? FX_LSB : s_nxt.val;
    floored_m_r <= floored_nxt;
    p_m_r <= mid_r[DIV_LAT-1].p;
    rel_m_r <= mid_r[DIV_LAT-1].rel;
    d_m_r <= mid_r[DIV_LAT-1].d;
    ovf_m_r <= mid_r[DIV_LAT-1].ovf | sa | sb | s_nxt.sat;

    ds_n_r <= ds_nxt.val;
    p_n_r <= p_m_r;
    rel_n_r <= rel_m_r;
    floored_n_r <= floored_m_r;
    ovf_n_r <= ovf_m_r | ds_nxt.sat;

    dsr_o_r <= dsr_nxt.val;
    p_o_r <= p_n_r;
    floored_o_r <= floored_n_r;
    ovf_o_r <= ovf_n_r | dsr_nxt.sat;

    tail_r[0] <= '{p: p_o_r, pr: pr_nxt.val, floored: floored_o_r,
                   ovf: ovf_o_r | pr_nxt.sat};
    for (int i = 1; i < TAIL_LEN; i++) begin
      tail_r[i] <= tail_r[i-1];
    end

    sq_r[0] <= sq_step(sq_init);
    for (int i = 1; i < SQ_W; i++) begin
      sq_r[i] <= sq_step(sq_r[i-1]);
    end
  end

  assign out_strobe = vld_r[OUT_STAGE];
  assign out_pressure = tail_r[TAIL_LEN-1].p;
  assign out_predicted_pressure = tail_r[TAIL_LEN-1].pr;
  assign out_speed_floored = tail_r[TAIL_LEN-1].floored;
  assign out_overflow = tail_r[TAIL_LEN-1].ovf;
  assign out_sound_speed = fxu_t'(sq_r[SQ_W-1].root);

`ifndef NO_ASSERTIONS
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(OUT_STAGE+1) out_strobe)
    else $error("result word missing at fixed latency");

  a_floored_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_speed_floored |-> out_sound_speed != '0)
    else $error("floored speed gave zero root");
`endif

endmodule
